@@ design/pid_keyed_process_table_unit_assert.svh @@
// Assertion macros for the process table unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PID_KEYED_PROCESS_TABLE_UNIT_ASSERT_SVH
`define PID_KEYED_PROCESS_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define PKPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pkpt: assertion failed");

// next-cycle implication
`define PKPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pkpt: assertion failed");

`endif

@@ design/pkpt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the process table unit.
// No dependencies.
package pkpt_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned SLOT_W      = 6;

  localparam logic [1:0] REQ_EXEC   = 2'd0;
  localparam logic [1:0] REQ_EXIT   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_RSV    = 2'd3;

  localparam logic [2:0] STS_UPDATED   = 3'd0;
  localparam logic [2:0] STS_ALLOCATED = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_REMOVED   = 3'd3;
  localparam logic [2:0] STS_NOT_FOUND = 3'd4;
  localparam logic [2:0] STS_FOUND     = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] proc_id;
    logic [31:0] parent_id;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic [63:0] event_time;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       out_parent_id;
    logic [31:0]       out_user_id;
    logic [31:0]       out_group_id;
    logic [31:0]       out_exec_count;
    logic [31:0]       out_episode_events;
    logic [63:0]       out_start_time;
    logic [63:0]       out_last_exec_time;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] parent;
    logic [31:0] user;
    logic [31:0] group;
    logic [63:0] start_time;
    logic [63:0] last_exec;
    logic [31:0] exec_cnt;
    logic [31:0] episode_events;
  } entry_t;

endpackage

@@ design/pkpt_cell.sv @@
`timescale 1ns / 1ps
// One table entry of the rotating entry ring.
// Depends on pkpt_pkg.
module pkpt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_en_i,
  input  logic             valid_i,
  input  pkpt_pkg::entry_t entry_i,
  output logic             valid_o,
  output pkpt_pkg::entry_t entry_o
);
  import pkpt_pkg::*;

  logic   valid_q;
  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      entry_q <= entry_i;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

@@ design/pkpt_ctrl.sv @@
`timescale 1ns / 1ps
// Request sequencer: scans the ring head, updates entries, holds the result.
// Depends on pkpt_pkg.
module pkpt_ctrl #(
  parameter int unsigned ENTRIES = pkpt_pkg::ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pkpt_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pkpt_pkg::rsp_t   out_rsp_o,
  input  logic             head_valid_i,
  input  pkpt_pkg::entry_t head_entry_i,
  output logic             tail_valid_o,
  output pkpt_pkg::entry_t tail_entry_o,
  output logic             shift_en_o
);
  import pkpt_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic          hit_found_q, hit_found_d;
  logic          free_found_q, free_found_d;
  logic          out_valid_q, out_valid_d;
  req_t          req_q;
  rsp_t          res_q, res_d;
  rsp_t          out_rsp_q;
  logic          req_ld, out_ld, last_idx, is_hit;
  entry_t        upd_entry, new_entry;

  function automatic rsp_t make_rsp(logic [2:0] sts, logic [IW-1:0] slot, entry_t e);
    rsp_t r;
    r.status             = sts;
    r.slot_index         = SLOT_W'(slot);
    r.out_parent_id      = e.parent;
    r.out_user_id        = e.user;
    r.out_group_id       = e.group;
    r.out_exec_count     = e.exec_cnt;
    r.out_episode_events = e.episode_events;
    r.out_start_time     = e.start_time;
    r.out_last_exec_time = e.last_exec;
    return r;
  endfunction

  always_comb begin
    upd_entry                = head_entry_i;
    upd_entry.parent         = req_q.parent_id;
    upd_entry.user           = req_q.user_id;
    upd_entry.group          = req_q.group_id;
    upd_entry.last_exec      = req_q.event_time;
    upd_entry.exec_cnt       = head_entry_i.exec_cnt + 32'd1;
    upd_entry.episode_events = head_entry_i.episode_events + 32'd1;

    new_entry.key            = req_q.proc_id;
    new_entry.parent         = req_q.parent_id;
    new_entry.user           = req_q.user_id;
    new_entry.group          = req_q.group_id;
    new_entry.start_time     = req_q.event_time;
    new_entry.last_exec      = req_q.event_time;
    new_entry.exec_cnt       = 32'd1;
    new_entry.episode_events = 32'd1;
  end

  assign last_idx = (idx_q == IW'(ENTRIES - 1));
  assign is_hit   = head_valid_i && (head_entry_i.key == req_q.proc_id) &&
                    (req_q.req_type != REQ_RSV) && !hit_found_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    hit_found_d  = hit_found_q;
    free_found_d = free_found_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && out_stall_i;
    tail_valid_o = head_valid_i;
    tail_entry_o = head_entry_i;
    shift_en_o   = 1'b0;
    req_ld       = 1'b0;
    out_ld       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_ld       = 1'b1;
          idx_d        = '0;
          free_idx_d   = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          res_d        = make_rsp(STS_NOT_FOUND, '0, '0);
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        shift_en_o = 1'b1;
        idx_d      = last_idx ? '0 : idx_q + 1'b1;
        if (is_hit) begin
          hit_found_d = 1'b1;
          case (req_q.req_type)
            REQ_EXEC: begin
              tail_entry_o = upd_entry;
              res_d        = make_rsp(STS_UPDATED, idx_q, upd_entry);
            end
            REQ_EXIT: begin
              tail_valid_o = 1'b0;
              res_d        = make_rsp(STS_REMOVED, idx_q, head_entry_i);
            end
            default: begin
              res_d = make_rsp(STS_FOUND, idx_q, head_entry_i);
            end
          endcase
        end
        if (!head_valid_i && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (last_idx) begin
          if (hit_found_q || is_hit) begin
            state_d = S_FLUSH;
          end else if (req_q.req_type == REQ_EXEC && (free_found_q || !head_valid_i)) begin
            state_d = S_PLACE;
          end else begin
            if (req_q.req_type == REQ_EXEC) begin
              res_d = make_rsp(STS_FULL, '0, '0);
            end
            state_d = S_FLUSH;
          end
        end
      end
      S_PLACE: begin
        shift_en_o = 1'b1;
        idx_d      = last_idx ? '0 : idx_q + 1'b1;
        if (idx_q == free_idx_q) begin
          tail_valid_o = 1'b1;
          tail_entry_o = new_entry;
          res_d        = make_rsp(STS_ALLOCATED, idx_q, new_entry);
        end
        if (last_idx) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      free_idx_q   <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_idx_q   <= free_idx_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (req_ld) begin
      req_q <= in_req_i;
    end
    if (out_ld) begin
      out_rsp_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ design/pid_keyed_process_table_unit.sv @@
`timescale 1ns / 1ps
`include "pid_keyed_process_table_unit_assert.svh"
// Process table keyed by process id: ring of entry cells plus sequencer.
// Depends on pkpt_pkg, pkpt_cell, pkpt_ctrl.
//
// Input channel in_valid_i / in_stall_o / in_req_i carries exec, exit and
// lookup requests; output channel out_valid_o / out_stall_i / out_rsp_o
// carries one response item per request.
// The entries sit in a ring of ENTRIES cells that rotates one place per
// cycle while the sequencer scans or places a request; the sequencer sits
// at the ring head. Exit, lookup, exec hits, full-table execs and the
// unused kind take one full turn of the ring before the response is ready.
// An exec that allocates takes a second full turn of the ring and places
// the new entry as its free slot passes the sequencer at the ring head.
// One request is served at a time; in_stall_o is high from accept until
// the response has been moved to the output register, so a finished
// response may wait there while the next request is taken and scanned.
// If the receiver stalls, the response holds and a following finished
// response waits in the sequencer until the output register frees.
// Reset clears every entry's valid mark at once; no clearing pass.
module pid_keyed_process_table_unit #(
  parameter int unsigned ENTRIES = pkpt_pkg::ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pkpt_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pkpt_pkg::rsp_t out_rsp_o
);
  import pkpt_pkg::*;

  logic   cell_valid [ENTRIES];
  entry_t cell_entry [ENTRIES];
  logic   tail_valid;
  entry_t tail_entry;
  logic   shift_en;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_ring
    if (i == ENTRIES - 1) begin : g_tail
      pkpt_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (shift_en),
        .valid_i    (tail_valid),
        .entry_i    (tail_entry),
        .valid_o    (cell_valid[i]),
        .entry_o    (cell_entry[i])
      );
    end else begin : g_mid
      pkpt_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (shift_en),
        .valid_i    (cell_valid[i+1]),
        .entry_i    (cell_entry[i+1]),
        .valid_o    (cell_valid[i]),
        .entry_o    (cell_entry[i])
      );
    end
  end

  pkpt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o),
    .head_valid_i (cell_valid[0]),
    .head_entry_i (cell_entry[0]),
    .tail_valid_o (tail_valid),
    .tail_entry_o (tail_entry),
    .shift_en_o   (shift_en)
  );

  `PKPT_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `PKPT_ASSERT_IMP(a_ring_still_when_idle, !in_stall_o, !shift_en)
  `PKPT_ASSERT_IMP(a_miss_is_zero, out_valid_o && (out_rsp_o.status == STS_FULL || out_rsp_o.status == STS_NOT_FOUND), out_rsp_o.slot_index == '0 && out_rsp_o.out_exec_count == '0 && out_rsp_o.out_start_time == '0)
  `PKPT_ASSERT_IMP(a_alloc_fresh, out_valid_o && out_rsp_o.status == STS_ALLOCATED, out_rsp_o.out_exec_count == 32'd1 && out_rsp_o.out_episode_events == 32'd1 && out_rsp_o.out_start_time == out_rsp_o.out_last_exec_time)

endmodule

@@ sim/process_table_checker.sv @@
`timescale 1ns / 1ps
// Response checker for pid_keyed_process_table_unit: keeps its own copy of the
// process table, works out the response to each accepted request and compares.
// Depends on pkpt_pkg.
module process_table_checker import pkpt_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  rsp_t out_rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  entry_t proc_tab  [ENTRIES];
  logic   slot_live [ENTRIES];
  rsp_t   due_rsp   [$];
  int     fails = 0;
  int     rsp_count = 0;

  assign fail_count_o = fails;

  // Lowest matching live slot wins; lowest free slot is allocated.
  function automatic rsp_t apply_request(input req_t rq);
    rsp_t res;
    int   hit;
    int   spare;
    int   slot;
    res   = '0;
    hit   = -1;
    spare = -1;
    slot  = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_live[i] && proc_tab[i].key == rq.proc_id) hit = i;
      if (!slot_live[i]) spare = i;
    end
    res.status = STS_NOT_FOUND;
    case (rq.req_type)
      REQ_EXEC: begin
        if (hit >= 0) begin
          slot = hit;
          proc_tab[slot].exec_cnt       = proc_tab[slot].exec_cnt + 32'd1;
          proc_tab[slot].episode_events = proc_tab[slot].episode_events + 32'd1;
          proc_tab[slot].parent         = rq.parent_id;
          proc_tab[slot].user           = rq.user_id;
          proc_tab[slot].group          = rq.group_id;
          proc_tab[slot].last_exec      = rq.event_time;
          res.status = STS_UPDATED;
        end else if (spare < 0) begin
          res.status = STS_FULL;
        end else begin
          slot = spare;
          slot_live[slot]               = 1'b1;
          proc_tab[slot].key            = rq.proc_id;
          proc_tab[slot].parent         = rq.parent_id;
          proc_tab[slot].user           = rq.user_id;
          proc_tab[slot].group          = rq.group_id;
          proc_tab[slot].start_time     = rq.event_time;
          proc_tab[slot].last_exec      = rq.event_time;
          proc_tab[slot].exec_cnt       = 32'd1;
          proc_tab[slot].episode_events = 32'd1;
          res.status = STS_ALLOCATED;
        end
      end
      REQ_EXIT: begin
        if (hit >= 0) begin
          slot = hit;
          slot_live[slot] = 1'b0;
          res.status = STS_REMOVED;
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          slot = hit;
          res.status = STS_FOUND;
        end
      end
      default: ;
    endcase
    if (slot >= 0) begin
      res.slot_index         = slot[SLOT_W-1:0];
      res.out_parent_id      = proc_tab[slot].parent;
      res.out_user_id        = proc_tab[slot].user;
      res.out_group_id       = proc_tab[slot].group;
      res.out_exec_count     = proc_tab[slot].exec_cnt;
      res.out_episode_events = proc_tab[slot].episode_events;
      res.out_start_time     = proc_tab[slot].start_time;
      res.out_last_exec_time = proc_tab[slot].last_exec;
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fails++;
    if (fails <= 100)
      $display("%0t ns: response %0d, %s: got %0h, want %0h",
               $time, rsp_count, what, got, want);
  endtask

  task automatic compare_response(input rsp_t got, input rsp_t want);
    if (got.status !== want.status)
      report("status", 64'(got.status), 64'(want.status));
    if (got.slot_index !== want.slot_index)
      report("slot_index", 64'(got.slot_index), 64'(want.slot_index));
    if (got.out_parent_id !== want.out_parent_id)
      report("out_parent_id", 64'(got.out_parent_id), 64'(want.out_parent_id));
    if (got.out_user_id !== want.out_user_id)
      report("out_user_id", 64'(got.out_user_id), 64'(want.out_user_id));
    if (got.out_group_id !== want.out_group_id)
      report("out_group_id", 64'(got.out_group_id), 64'(want.out_group_id));
    if (got.out_exec_count !== want.out_exec_count)
      report("out_exec_count", 64'(got.out_exec_count), 64'(want.out_exec_count));
    if (got.out_episode_events !== want.out_episode_events)
      report("out_episode_events", 64'(got.out_episode_events),
             64'(want.out_episode_events));
    if (got.out_start_time !== want.out_start_time)
      report("out_start_time", got.out_start_time, want.out_start_time);
    if (got.out_last_exec_time !== want.out_last_exec_time)
      report("out_last_exec_time", got.out_last_exec_time, want.out_last_exec_time);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_live[i] = 1'b0;
        proc_tab[i]  = '0;
      end
      due_rsp.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_rsp.size() == 0)
          report("item with nothing due, status", 64'(out_rsp_i.status), '0);
        else
          compare_response(out_rsp_i, due_rsp.pop_front());
        rsp_count++;
      end
      if (in_valid_i && !in_stall_i) due_rsp.push_back(apply_request(in_req_i));
      pending_o = due_rsp.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the process table testbench: clock, reset, request stimulus and
// output back-pressure, with the verdict at the end.
// Depends on pkpt_pkg, pid_keyed_process_table_unit and process_table_checker.
module testbench;
  import pkpt_pkg::*;

  localparam int unsigned ENTRIES  = ENTRIES_DEF;
  localparam int unsigned KEY_POOL = 96;
  localparam int          ITEMS    = 900;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_rsp;
  int          fail_count;
  int          pending;
  logic [31:0] key_pool [KEY_POOL];
  int          sent = 0;
  bit          calm = 1'b0;
  int          stall_hold = 0;
  int          stall_pick;

  pid_keyed_process_table_unit #(.ENTRIES(ENTRIES)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  process_table_checker #(.ENTRIES(ENTRIES)) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // back-pressure: short bursts mostly, occasional long stalls and calm stretches
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(0, 6);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(0, 3);
      end else if (stall_pick < 95) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(100, 400);
      end else begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(20, 80);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] key);
    req_t rq;
    rq.req_type   = kind;
    rq.proc_id    = key;
    rq.parent_id  = $urandom;
    rq.user_id    = $urandom;
    rq.group_id   = $urandom;
    rq.event_time = {$urandom, $urandom};
    return rq;
  endfunction

  task automatic send_request(input req_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= rq;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t        rq;
    int          psize;
    int          r;
    logic [1:0]  kind;
    logic [31:0] key;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused request kind, both key extremes
    send_request(make_req(REQ_LOOKUP, 32'h0));
    send_request(make_req(REQ_EXIT, '1));
    rq = '1;
    rq.req_type = REQ_RSV;
    send_request(rq);
    rq = '0;
    rq.req_type = REQ_EXEC;
    send_request(rq);
    rq = '1;
    rq.req_type = REQ_EXEC;
    send_request(rq);
    send_request(make_req(REQ_EXEC, 32'h0));
    send_request(make_req(REQ_LOOKUP, '1));
    // exit keeps the stored fields; a new exec starts the entry afresh
    send_request(make_req(REQ_EXIT, 32'h0));
    send_request(make_req(REQ_LOOKUP, 32'h0));
    send_request(make_req(REQ_EXIT, 32'h0));
    send_request(make_req(REQ_EXEC, 32'h0));
    rq = '1;
    rq.req_type = REQ_RSV;
    send_request(rq);
    send_request(make_req(REQ_LOOKUP, '1));
    send_request(make_req(REQ_EXEC, '1));
    send_request(make_req(REQ_EXIT, '1));
    send_request(make_req(REQ_EXEC, 32'h0000_3039));
    send_request(make_req(REQ_EXEC, 32'h5555_aaaa));
    hold_until_drained();

    key_pool[0] = 32'h0;
    key_pool[1] = '1;
    key_pool[2] = 32'h0000_3039;
    key_pool[3] = 32'h5555_aaaa;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    // more keys than slots: the table fills and later execs find it full
    for (int i = 0; i < KEY_POOL; i++) send_request(make_req(REQ_EXEC, key_pool[i]));

    while (sent < ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: begin
          for (int i = 0; i < KEY_POOL; i++) send_request(make_req(REQ_EXEC, key_pool[i]));
        end
        1: begin
          for (int i = 0; i < KEY_POOL; i++) begin
            kind = ($urandom_range(0, 3) == 0) ? REQ_LOOKUP : REQ_EXIT;
            send_request(make_req(kind, key_pool[i]));
          end
        end
        default: begin
          r = $urandom_range(0, 2);
          psize = (r == 0) ? 6 : (r == 1) ? 32 : KEY_POOL;
          for (int n = 0; n < 100; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) kind = REQ_EXEC;
            else if (r < 65) kind = REQ_EXIT;
            else if (r < 93) kind = REQ_LOOKUP;
            else kind = REQ_RSV;
            // stray keys only on requests that cannot allocate
            if (kind != REQ_EXEC && $urandom_range(0, 99) < 15) key = $urandom;
            else key = key_pool[$urandom_range(0, psize - 1)];
            send_request(make_req(kind, key));
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (2 * ENTRIES + 8) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
